FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked on clk_i, off while rst_ni is low
`define MME_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never hold
`define MME_ASSERT_NEVER(label, cond, msg) \
  `MME_ASSERT(label, !(cond), msg)

`endif

FILE: src/mme_pkg.sv
package mme_pkg;

  localparam int MAX_DIM   = 8;
  localparam int ELEM_BITS = 16;
  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int PROD_W    = 2 * ELEM_BITS;
  localparam int SUM_W     = 40;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = DIM_W;

  typedef enum logic [1:0] {
    ACT_LOAD_A = 2'd0,
    ACT_LOAD_B = 2'd1,
    ACT_START  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS   = 2'd0,
    CFG_INNER  = 2'd1,
    CFG_COLS   = 2'd2,
    CFG_BTRANS = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_first;
  } mac_ctrl_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) r = DIM_W'(1);
    else if (d > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    return r;
  endfunction

endpackage

FILE: src/matrix_multiply_engine.sv
// Fixed-point matrix multiply engine, C = A * B, Q8.8 elements, Q24.16 sums.
// Input words enter on start/busy: a word is taken at a clock edge where start
// is high and busy is low. Action load A or load B writes one element into the
// A or B store; a load is taken every cycle while busy is low. A load outside
// the configured dimensions writes nothing and gives one error result
// (status 1, last 1, dot_sum 0) on the cycle after it is taken.
// A start word runs the product: busy rises on the next cycle and stays high
// until the final accumulate of the run. One multiply-accumulate unit is shared
// by all products; each inner step passes three states (store read, multiply,
// accumulate). Results come row-major, one per element of C, last marked.
// Each result is shown for one cycle with result_valid_o; there is no stall.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user
// must write it only while idle, and the block itself does not enforce this.
// Reset sets the dimensions to 8 by 8 by 8, B untransposed, and the sequencer
// idle. Store contents are undefined until loaded.
`include "assert_macros.svh"

module matrix_multiply_engine_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           action_i,
  input  logic [mme_pkg::IDX_W-1:0]            row_index_i,
  input  logic [mme_pkg::IDX_W-1:0]            col_index_i,
  input  logic signed [15:0]                   element_value_i,
  input  logic                                 cfg_we_i,
  input  logic [mme_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [mme_pkg::CFG_W-1:0]            cfg_wdata_i,
  output logic                                 result_valid_o,
  output logic [mme_pkg::IDX_W-1:0]            out_row_o,
  output logic [mme_pkg::IDX_W-1:0]            out_col_o,
  output logic signed [mme_pkg::SUM_W-1:0]     dot_sum_o,
  output logic                                 status_o,
  output logic                                 last_o
);
  import mme_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_ACC  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [DIM_W-1:0] rows_q, inner_q, cols_q;
  logic             btr_q;
  logic [DIM_W-1:0] nr, nk, nc;

  logic [IDX_W-1:0] r_q, c_q, k_q;

  logic signed [ELEM_BITS-1:0] a_mem [DEPTH];
  logic signed [ELEM_BITS-1:0] b_mem [DEPTH];
  logic signed [ELEM_BITS-1:0] rd_a_q, rd_b_q;
  logic [ADDR_W-1:0]           a_raddr, b_raddr, wr_addr;

  logic                        take;
  logic                        is_load_a, is_load_b, is_start;
  logic [DIM_W-1:0]            lim_r, lim_c;
  logic                        in_range;
  logic signed [ELEM_BITS-1:0] elem;

  logic last_k, last_c, last_r;

  mac_ctrl_t               mac_ctrl;
  logic signed [SUM_W-1:0] mac_sum;

  logic                    res_valid_q;
  logic [IDX_W-1:0]        res_row_q, res_col_q;
  logic signed [SUM_W-1:0] res_sum_q;
  logic                    res_status_q, res_last_q;

  assign nr = clamp_dim(rows_q);
  assign nk = clamp_dim(inner_q);
  assign nc = clamp_dim(cols_q);

  assign busy = (state_q != ST_IDLE);
  assign take = start && !busy;

  always_comb begin
    is_load_a = 1'b0;
    is_load_b = 1'b0;
    is_start  = 1'b0;
    unique case (action_e'(action_i))
      ACT_LOAD_A: is_load_a = 1'b1;
      ACT_LOAD_B: is_load_b = 1'b1;
      ACT_START:  is_start  = 1'b1;
      default:    ;
    endcase
  end

  always_comb begin
    if (is_load_a) begin
      lim_r = nr;
      lim_c = nk;
    end else if (btr_q) begin
      lim_r = nc;
      lim_c = nk;
    end else begin
      lim_r = nk;
      lim_c = nc;
    end
  end

  assign in_range = (DIM_W'(row_index_i) < lim_r) && (DIM_W'(col_index_i) < lim_c);
  assign elem     = ELEM_BITS'(element_value_i);
  assign wr_addr  = {row_index_i, col_index_i};
  assign a_raddr  = {r_q, k_q};
  assign b_raddr  = btr_q ? {c_q, k_q} : {k_q, c_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= DIM_W'(MAX_DIM);
      inner_q <= DIM_W'(MAX_DIM);
      cols_q  <= DIM_W'(MAX_DIM);
      btr_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ROWS:   rows_q  <= cfg_wdata_i;
        CFG_INNER:  inner_q <= cfg_wdata_i;
        CFG_COLS:   cols_q  <= cfg_wdata_i;
        CFG_BTRANS: btr_q   <= cfg_wdata_i[0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && is_load_a && in_range) a_mem[wr_addr] <= elem;
    rd_a_q <= a_mem[a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (take && is_load_b && in_range) b_mem[wr_addr] <= elem;
    rd_b_q <= b_mem[b_raddr];
  end

  assign last_k = (DIM_W'(k_q) == nk - DIM_W'(1));
  assign last_c = (DIM_W'(c_q) == nc - DIM_W'(1));
  assign last_r = (DIM_W'(r_q) == nr - DIM_W'(1));

  always_comb begin
    state_d            = state_q;
    mac_ctrl.mul_en    = 1'b0;
    mac_ctrl.acc_en    = 1'b0;
    mac_ctrl.acc_first = (k_q == '0);
    unique case (state_q)
      ST_IDLE: if (take && is_start) state_d = ST_READ;
      ST_READ: state_d = ST_MUL;
      ST_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        state_d         = ST_ACC;
      end
      ST_ACC: begin
        mac_ctrl.acc_en = 1'b1;
        state_d = (last_k && last_c && last_r) ? ST_IDLE : ST_READ;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      r_q     <= '0;
      c_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE) begin
        r_q <= '0;
        c_q <= '0;
        k_q <= '0;
      end else if (state_q == ST_ACC) begin
        if (!last_k) begin
          k_q <= k_q + IDX_W'(1);
        end else begin
          k_q <= '0;
          if (!last_c) begin
            c_q <= c_q + IDX_W'(1);
          end else begin
            c_q <= '0;
            r_q <= r_q + IDX_W'(1);
          end
        end
      end
    end
  end

  mme_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (rd_a_q),
    .b_i    (rd_b_q),
    .sum_o  (mac_sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (take && (is_load_a || is_load_b) && !in_range)
                  || (state_q == ST_ACC && last_k);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && (is_load_a || is_load_b) && !in_range) begin
      res_row_q    <= row_index_i;
      res_col_q    <= col_index_i;
      res_sum_q    <= '0;
      res_status_q <= 1'b1;
      res_last_q   <= 1'b1;
    end else if (state_q == ST_ACC && last_k) begin
      res_row_q    <= r_q;
      res_col_q    <= c_q;
      res_sum_q    <= mac_sum;
      res_status_q <= 1'b0;
      res_last_q   <= last_c && last_r;
    end
  end

  assign result_valid_o = res_valid_q;
  assign out_row_o      = res_row_q;
  assign out_col_o      = res_col_q;
  assign dot_sum_o      = res_sum_q;
  assign status_o       = res_status_q;
  assign last_o         = res_last_q;

  `MME_ASSERT(a_start_busy, (take && is_start) |=> busy, "start word did not raise busy")
  `MME_ASSERT(a_final_idle, (result_valid_o && last_o && !status_o) |-> !busy,
              "busy after final result of a run")
  `MME_ASSERT_NEVER(a_err_in_run, result_valid_o && status_o && busy,
                    "error result during a run")

endmodule

FILE: src/mme_mac.sv
module mme_mac (
  input  logic                                 clk_i,
  input  mme_pkg::mac_ctrl_t                   ctrl_i,
  input  logic signed [mme_pkg::ELEM_BITS-1:0] a_i,
  input  logic signed [mme_pkg::ELEM_BITS-1:0] b_i,
  output logic signed [mme_pkg::SUM_W-1:0]     sum_o
);
  import mme_pkg::*;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0]  acc_q;
  logic signed [SUM_W-1:0]  prod_ext;
  logic signed [SUM_W-1:0]  base;

  assign prod_ext = {{(SUM_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign base     = ctrl_i.acc_first ? '0 : acc_q;
  assign sum_o    = base + prod_ext;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) prod_q <= a_i * b_i;
    if (ctrl_i.acc_en) acc_q <= sum_o;
  end

endmodule

FILE: sim/matrix_multiply_engine_core_tb.sv
module matrix_multiply_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mme_pkg::*;

  localparam int RANDOM_WORDS = 320;
  localparam int QUIET_TAIL   = 60;
  localparam int CYCLE_LIMIT  = 2000000;

  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [SUM_W-1:0] dot_sum;
    logic                    status;
    logic                    last;
  } result_word_t;

  typedef struct {
    bit               is_cfg;
    cfg_idx_e         reg_idx;
    logic [CFG_W-1:0] reg_data;
    action_e          act;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [15:0]      value;
    bit               typed;
    result_word_t     want;
  } stim_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [1:0]              action_i;
  logic [IDX_W-1:0]        row_index_i;
  logic [IDX_W-1:0]        col_index_i;
  logic signed [15:0]      element_value_i;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_idx_i;
  logic [CFG_W-1:0]        cfg_wdata_i;
  logic                    result_valid_o;
  logic [IDX_W-1:0]        out_row_o;
  logic [IDX_W-1:0]        out_col_o;
  logic signed [SUM_W-1:0] dot_sum_o;
  logic                    status_o;
  logic                    last_o;

  matrix_multiply_engine_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .action_i        (action_i),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .result_valid_o  (result_valid_o),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .dot_sum_o       (dot_sum_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

  // shadow of the engine
  logic signed [15:0] shadow_a [DEPTH];
  logic signed [15:0] shadow_b [DEPTH];
  bit                 a_loaded [DEPTH];
  bit                 b_loaded [DEPTH];
  logic [CFG_W-1:0]   reg_rows;
  logic [CFG_W-1:0]   reg_inner;
  logic [CFG_W-1:0]   reg_cols;
  bit                 reg_btrans;

  result_word_t results_due[$];
  result_word_t fresh_results[$];
  stim_row_t    directed_rows[$];

  bit           use_typed;
  result_word_t typed_result;
  bit           gaps_on;
  int           word_count;
  int           fail_count;
  int           cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int eff_dim(logic [CFG_W-1:0] d);
    if (d == '0) return 1;
    if (d > CFG_W'(MAX_DIM)) return MAX_DIM;
    return int'(d);
  endfunction

  function automatic bit operands_loaded();
    int nr;
    int nk;
    int nc;
    nr = eff_dim(reg_rows);
    nk = eff_dim(reg_inner);
    nc = eff_dim(reg_cols);
    for (int r = 0; r < nr; r++)
      for (int k = 0; k < nk; k++)
        if (!a_loaded[r * MAX_DIM + k]) return 1'b0;
    for (int c = 0; c < nc; c++)
      for (int k = 0; k < nk; k++)
        if (reg_btrans ? !b_loaded[c * MAX_DIM + k] : !b_loaded[k * MAX_DIM + c]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void compute_word_results(action_e act, logic [IDX_W-1:0] r,
                                               logic [IDX_W-1:0] c, logic signed [15:0] v);
    int                      nr;
    int                      nk;
    int                      nc;
    int                      lim_r;
    int                      lim_c;
    logic signed [SUM_W-1:0] acc;
    logic signed [31:0]      prod;
    result_word_t            res;
    fresh_results.delete();
    nr = eff_dim(reg_rows);
    nk = eff_dim(reg_inner);
    nc = eff_dim(reg_cols);
    case (act) inside
      ACT_LOAD_A, ACT_LOAD_B: begin
        if (act == ACT_LOAD_A) begin
          lim_r = nr;
          lim_c = nk;
        end else if (reg_btrans) begin
          lim_r = nc;
          lim_c = nk;
        end else begin
          lim_r = nk;
          lim_c = nc;
        end
        if (int'(r) >= lim_r || int'(c) >= lim_c) begin
          res = '{out_row: r, out_col: c, dot_sum: '0, status: 1'b1, last: 1'b1};
          fresh_results.push_back(res);
        end else if (act == ACT_LOAD_A) begin
          shadow_a[int'(r) * MAX_DIM + int'(c)] = v;
          a_loaded[int'(r) * MAX_DIM + int'(c)] = 1'b1;
        end else begin
          shadow_b[int'(r) * MAX_DIM + int'(c)] = v;
          b_loaded[int'(r) * MAX_DIM + int'(c)] = 1'b1;
        end
      end
      ACT_START: begin
        for (int i = 0; i < nr; i++) begin
          for (int j = 0; j < nc; j++) begin
            acc = '0;
            for (int k = 0; k < nk; k++) begin
              prod = shadow_a[i * MAX_DIM + k] *
                     (reg_btrans ? shadow_b[j * MAX_DIM + k] : shadow_b[k * MAX_DIM + j]);
              acc = acc + prod;
            end
            res.out_row = IDX_W'(i);
            res.out_col = IDX_W'(j);
            res.dot_sum = acc;
            res.status  = 1'b0;
            res.last    = (i == nr - 1) && (j == nc - 1);
            fresh_results.push_back(res);
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i) begin : check_and_predict
    result_word_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (results_due.size() == 0) begin
          $error("result word with nothing due: out_row %0d out_col %0d dot_sum %0d",
                 out_row_o, out_col_o, dot_sum_o);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          if (out_row_o !== want.out_row) begin
            $error("out_row: expected %0d, actual %0d", want.out_row, out_row_o);
            fail_count++;
          end
          if (out_col_o !== want.out_col) begin
            $error("out_col: expected %0d, actual %0d", want.out_col, out_col_o);
            fail_count++;
          end
          if (dot_sum_o !== want.dot_sum) begin
            $error("dot_sum: expected %0d, actual %0d", want.dot_sum, dot_sum_o);
            fail_count++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_o);
            fail_count++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last_o);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        compute_word_results(action_e'(action_i), row_index_i, col_index_i, element_value_i);
        if (use_typed) results_due.push_back(typed_result);
        else foreach (fresh_results[n]) results_due.push_back(fresh_results[n]);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 11)) inside
      0: return '0;
      1: return CFG_W'(15);
      2: return CFG_W'(MAX_DIM);
      [3:4]: return CFG_W'($urandom_range(4, 15));
      default: return CFG_W'($urandom_range(1, 3));
    endcase
  endfunction

  function automatic stim_row_t blank_row();
    stim_row_t s;
    s.is_cfg   = 1'b0;
    s.reg_idx  = CFG_ROWS;
    s.reg_data = '0;
    s.act      = ACT_NONE;
    s.row      = '0;
    s.col      = '0;
    s.value    = '0;
    s.typed    = 1'b0;
    s.want     = '0;
    return s;
  endfunction

  function automatic stim_row_t cfg_row(cfg_idx_e idx, logic [CFG_W-1:0] data);
    stim_row_t s;
    s = blank_row();
    s.is_cfg   = 1'b1;
    s.reg_idx  = idx;
    s.reg_data = data;
    return s;
  endfunction

  function automatic stim_row_t word_row(action_e act, logic [IDX_W-1:0] r,
                                         logic [IDX_W-1:0] c, logic [15:0] v);
    stim_row_t s;
    s = blank_row();
    s.act   = act;
    s.row   = r;
    s.col   = c;
    s.value = v;
    return s;
  endfunction

  function automatic stim_row_t fault_row(action_e act, logic [IDX_W-1:0] r,
                                          logic [IDX_W-1:0] c);
    stim_row_t s;
    s       = word_row(act, r, c, 16'h5a5a);
    s.typed = 1'b1;
    s.want  = '{out_row: r, out_col: c, dot_sum: '0, status: 1'b1, last: 1'b1};
    return s;
  endfunction

  function automatic stim_row_t sum_row(logic signed [SUM_W-1:0] s_want);
    stim_row_t s;
    s       = word_row(ACT_START, '0, '0, '0);
    s.typed = 1'b1;
    s.want  = '{out_row: '0, out_col: '0, dot_sum: s_want, status: 1'b0, last: 1'b1};
    return s;
  endfunction

  task automatic settle();
    start <= 1'b0;
    @(negedge clk_i);
    while (results_due.size() != 0 || busy) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_ROWS:   reg_rows   = data;
      CFG_INNER:  reg_inner  = data;
      CFG_COLS:   reg_cols   = data;
      CFG_BTRANS: reg_btrans = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_word(action_e act, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                           logic [15:0] v, bit typed = 1'b0, result_word_t want = '0);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start           <= 1'b0;
      action_i        <= 2'($urandom);
      row_index_i     <= IDX_W'($urandom);
      col_index_i     <= IDX_W'($urandom);
      element_value_i <= 16'($urandom);
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    start           <= 1'b1;
    action_i        <= act;
    row_index_i     <= r;
    col_index_i     <= c;
    element_value_i <= v;
    use_typed       <= typed;
    typed_result    <= want;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (act != ACT_NONE) word_count++;
    @(negedge clk_i);
  endtask

  task automatic send_noise();
    action_e act;
    act = action_e'($urandom_range(0, 3));
    if (act == ACT_START && !operands_loaded()) act = ACT_LOAD_A;
    send_word(act, IDX_W'($urandom), IDX_W'($urandom), pick_value());
  endtask

  task automatic fill_operands();
    int nr;
    int nk;
    int nc;
    nr = eff_dim(reg_rows);
    nk = eff_dim(reg_inner);
    nc = eff_dim(reg_cols);
    for (int r = 0; r < nr; r++) begin
      for (int k = 0; k < nk; k++) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        send_word(ACT_LOAD_A, IDX_W'(r), IDX_W'(k), pick_value());
      end
    end
    for (int c = 0; c < nc; c++) begin
      for (int k = 0; k < nk; k++) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        if (reg_btrans) send_word(ACT_LOAD_B, IDX_W'(c), IDX_W'(k), pick_value());
        else send_word(ACT_LOAD_B, IDX_W'(k), IDX_W'(c), pick_value());
      end
    end
  endtask

  initial begin
    start           <= 1'b0;
    action_i        <= ACT_NONE;
    row_index_i     <= '0;
    col_index_i     <= '0;
    element_value_i <= '0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= CFG_ROWS;
    cfg_wdata_i     <= '0;
    use_typed       <= 1'b0;
    typed_result    <= '0;
    rst_ni          <= 1'b0;
    gaps_on    = 1'b1;
    word_count = 0;
    fail_count = 0;
    reg_rows   = CFG_W'(MAX_DIM);
    reg_inner  = CFG_W'(MAX_DIM);
    reg_cols   = CFG_W'(MAX_DIM);
    reg_btrans = 1'b0;
    foreach (shadow_a[n]) begin
      shadow_a[n] = '0;
      shadow_b[n] = '0;
      a_loaded[n] = 1'b0;
      b_loaded[n] = 1'b0;
    end

    directed_rows.push_back(word_row(ACT_NONE, 3'd7, 3'd7, 16'hffff));
    directed_rows.push_back(cfg_row(CFG_ROWS, 4'd0));
    directed_rows.push_back(cfg_row(CFG_INNER, 4'd15));
    directed_rows.push_back(cfg_row(CFG_COLS, 4'd1));
    directed_rows.push_back(word_row(ACT_LOAD_A, 3'd0, 3'd7, 16'h1234));
    directed_rows.push_back(fault_row(ACT_LOAD_A, 3'd1, 3'd0));
    directed_rows.push_back(word_row(ACT_LOAD_B, 3'd7, 3'd0, 16'h0100));
    directed_rows.push_back(fault_row(ACT_LOAD_B, 3'd0, 3'd1));
    directed_rows.push_back(cfg_row(CFG_INNER, 4'd1));
    directed_rows.push_back(fault_row(ACT_LOAD_A, 3'd0, 3'd7));
    directed_rows.push_back(word_row(ACT_LOAD_A, 3'd0, 3'd0, 16'h7fff));
    directed_rows.push_back(word_row(ACT_LOAD_B, 3'd0, 3'd0, 16'h7fff));
    directed_rows.push_back(sum_row(40'sd1073676289));
    directed_rows.push_back(word_row(ACT_LOAD_A, 3'd0, 3'd0, 16'h8000));
    directed_rows.push_back(sum_row(-40'sd1073709056));
    directed_rows.push_back(word_row(ACT_LOAD_B, 3'd0, 3'd0, 16'h8000));
    directed_rows.push_back(sum_row(40'sd1073741824));
    directed_rows.push_back(cfg_row(CFG_BTRANS, 4'd1));
    directed_rows.push_back(cfg_row(CFG_COLS, 4'd2));
    directed_rows.push_back(word_row(ACT_LOAD_B, 3'd1, 3'd0, 16'h0100));
    directed_rows.push_back(fault_row(ACT_LOAD_B, 3'd0, 3'd1));
    directed_rows.push_back(fault_row(ACT_LOAD_B, 3'd2, 3'd0));
    directed_rows.push_back(word_row(ACT_START, 3'd0, 3'd0, 16'h0000));

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[n]) begin
      if (directed_rows[n].is_cfg) begin
        settle();
        write_reg(directed_rows[n].reg_idx, directed_rows[n].reg_data);
      end else begin
        send_word(directed_rows[n].act, directed_rows[n].row, directed_rows[n].col,
                  directed_rows[n].value, directed_rows[n].typed, directed_rows[n].want);
      end
    end

    word_count = 0;
    while (word_count < RANDOM_WORDS) begin
      gaps_on = word_count < RANDOM_WORDS - QUIET_TAIL;
      if (gaps_on) begin
        settle();
        if ($urandom_range(0, 1) == 0) write_reg(CFG_ROWS, pick_dim());
        if ($urandom_range(0, 1) == 0) write_reg(CFG_INNER, pick_dim());
        if ($urandom_range(0, 1) == 0) write_reg(CFG_COLS, pick_dim());
        if ($urandom_range(0, 2) == 0) write_reg(CFG_BTRANS, CFG_W'($urandom));
      end
      if ($urandom_range(0, 4) != 0) begin
        fill_operands();
        send_word(ACT_START, IDX_W'($urandom), IDX_W'($urandom), 16'($urandom));
        if ($urandom_range(0, 3) == 0)
          send_word(ACT_START, IDX_W'($urandom), IDX_W'($urandom), 16'($urandom));
      end else begin
        repeat ($urandom_range(3, 8)) send_noise();
        if (operands_loaded())
          send_word(ACT_START, IDX_W'($urandom), IDX_W'($urandom), 16'($urandom));
      end
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
